@@ design/dea_pkg.sv @@
// shared codes, constants and the queued item type of the decimal exponent unit
package dea_pkg;

   localparam logic [2:0] FUNC_CMP = 3'd0;
   localparam logic [2:0] FUNC_ADD = 3'd1;
   localparam logic [2:0] FUNC_SUB = 3'd2;
   localparam logic [2:0] FUNC_MUL = 3'd3;
   localparam logic [2:0] FUNC_DIV = 3'd4;

   localparam logic [2:0] KIND_ZERO   = 3'd0;
   localparam logic [2:0] KIND_ORDER  = 3'd1;
   localparam logic [2:0] KIND_PASS   = 3'd2;
   localparam logic [2:0] KIND_ADDSUB = 3'd3;
   localparam logic [2:0] KIND_MUL    = 3'd4;
   localparam logic [2:0] KIND_DIV    = 3'd5;

   localparam int ADD_GAP   = 15;
   localparam int ALIGN_CAP = 12;
   localparam int EXP_LIMIT = 99999;
   localparam int DIV_SHIFT = 32;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [1:0]  order;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               sub;
      logic [3:0]         cnt;
      logic signed [19:0] e;
   } dea_item_type;

endpackage

@@ design/decimal_exponent_arith_unit_core.sv @@
// top level of the decimal exponent arithmetic unit
// Compare, add, subtract, multiply and divide on numbers of the form
// mantissa / 2^FRACTION_BITS * 10^exponent. One request gives one response.
// The front end classifies a request in the accepting cycle and parks it in a
// two-entry queue; one engine works on one item at a time. Compare, wide-gap
// add, unused codes and divide by zero go straight to the result; add and
// subtract align across at most 12 decades before normalization; divide runs
// the two-bit-per-cycle quotient loop before normalization. Normalization
// shifts down one decade at a time in 16-bit digit groups through the
// divide-by-ten unit and shifts up one decade per times-ten step.
module decimal_exponent_arith_unit_core #(
   parameter int FRACTION_BITS = 27
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_a_mantissa,
   input  logic signed [17:0] req_a_exponent,
   input  logic signed [31:0] req_b_mantissa,
   input  logic signed [17:0] req_b_exponent,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_mantissa,
   output logic signed [17:0] rsp_res_exponent,
   output logic signed [1:0]  rsp_order
);
   import dea_pkg::*;

   dea_item_type front_item;
   dea_item_type head_item;
   logic         full;
   logic         head_valid;
   logic         pop;

   assign req_stall = full;

   dea_front u_front (
      .func       (req_func),
      .a_mantissa (req_a_mantissa),
      .a_exponent (req_a_exponent),
      .b_mantissa (req_b_mantissa),
      .b_exponent (req_b_exponent),
      .item       (front_item)
   );

   dea_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !full),
      .push_item  (front_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   dea_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (head_valid),
      .item             (head_item),
      .item_pop         (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_res_mantissa (rsp_res_mantissa),
      .rsp_res_exponent (rsp_res_exponent),
      .rsp_order        (rsp_order)
   );

endmodule

@@ design/dea_front.sv @@
// front end: compares operands and sorts each request into a work item
module dea_front (
   input  logic [2:0]          func,
   input  logic signed [31:0]  a_mantissa,
   input  logic signed [17:0]  a_exponent,
   input  logic signed [31:0]  b_mantissa,
   input  logic signed [17:0]  b_exponent,
   output dea_pkg::dea_item_type item
);
   import dea_pkg::*;

   logic signed [19:0] ea;
   logic signed [19:0] eb;
   logic signed [19:0] d;
   logic signed [19:0] nd;
   logic [3:0]         cnt_pos;
   logic [3:0]         cnt_neg;
   logic signed [1:0]  ord;

   always_comb begin
      ea = {{2{a_exponent[17]}}, a_exponent};
      eb = {{2{b_exponent[17]}}, b_exponent};
      d  = ea - eb;
      nd = eb - ea;
      cnt_pos = (d > 20'sd12) ? 4'(ALIGN_CAP) : d[3:0];
      cnt_neg = (nd > 20'sd12) ? 4'(ALIGN_CAP) : nd[3:0];
      priority if (ea > eb) begin
         ord = 2'sd1;
      end else if (ea < eb) begin
         ord = -2'sd1;
      end else if (a_mantissa > b_mantissa) begin
         ord = 2'sd1;
      end else if (a_mantissa < b_mantissa) begin
         ord = -2'sd1;
      end else begin
         ord = 2'sd0;
      end

      item.kind  = KIND_ZERO;
      item.order = 2'sd0;
      item.x     = a_mantissa;
      item.y     = b_mantissa;
      item.sub   = 1'b0;
      item.cnt   = 4'd0;
      item.e     = ea;

      unique case (func)
         FUNC_CMP: begin
            item.kind  = KIND_ORDER;
            item.order = ord;
         end
         FUNC_ADD: begin
            priority if (d > 20'sd15) begin
               item.kind = KIND_PASS;
            end else if (d < -20'sd15) begin
               item.kind = KIND_PASS;
               item.x    = b_mantissa;
               item.e    = eb;
            end else if (d >= 20'sd0) begin
               item.kind = KIND_ADDSUB;
               item.cnt  = cnt_pos;
            end else begin
               item.kind = KIND_ADDSUB;
               item.x    = b_mantissa;
               item.y    = a_mantissa;
               item.cnt  = cnt_neg;
               item.e    = eb;
            end
         end
         FUNC_SUB: begin
            priority if (ord == 2'sd1) begin
               item.kind = KIND_ADDSUB;
               item.sub  = 1'b1;
               item.cnt  = cnt_pos;
            end else if (ord == 2'sd0) begin
               item.kind = KIND_ADDSUB;
               item.sub  = 1'b1;
               item.e    = eb;
            end else begin
               item.kind = KIND_ZERO;
            end
         end
         FUNC_MUL: begin
            item.kind = KIND_MUL;
            item.e    = ea + eb;
         end
         FUNC_DIV: begin
            item.kind = (b_mantissa == 32'sd0) ? KIND_ZERO : KIND_DIV;
            item.e    = d;
         end
         default: begin
            item.kind = KIND_ZERO;
         end
      endcase
   end

endmodule

@@ design/dea_queue.sv @@
// two-entry queue between the front end and the arithmetic engine
module dea_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dea_pkg::dea_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output dea_pkg::dea_item_type head_item
);
   import dea_pkg::*;

   dea_item_type slot_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

@@ design/dea_back.sv @@
// arithmetic engine: alignment, multiply, divide, normalization and result register
module dea_back #(
   parameter int FRACTION_BITS = 27
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  dea_pkg::dea_item_type item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_res_mantissa,
   output logic signed [17:0]    rsp_res_exponent,
   output logic signed [1:0]     rsp_order
);
   import dea_pkg::*;

   localparam logic [63:0] ONE        = 64'd1 << FRACTION_BITS;
   localparam logic [63:0] TOP        = 64'd10 * ONE - ((ONE + 64'd999999) / 64'd1000000);
   localparam logic [63:0] MUL10_MAX  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;
   localparam logic [6:0]  FB_SHIFT   = 7'(FRACTION_BITS);
   localparam logic [6:0]  PROD_SHIFT = 7'(2 * FRACTION_BITS);
   localparam logic [6:0]  QUO_SHIFT  = 7'(DIV_SHIFT);
   localparam logic [23:0] RECIP10    = 24'd13421773;
   localparam logic signed [19:0] ELIM = 20'(EXP_LIMIT);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ALIGN = 4'd1;
   localparam logic [3:0] S_SUM   = 4'd2;
   localparam logic [3:0] S_QDIV  = 4'd3;
   localparam logic [3:0] S_ZCHK  = 4'd4;
   localparam logic [3:0] S_DOWN  = 4'd5;
   localparam logic [3:0] S_UP    = 4'd6;
   localparam logic [3:0] S_PACK  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic               neg_ff, neg_in;
   logic [63:0]        mag_ff, mag_in;
   logic [6:0]         shift_ff, shift_in;
   logic signed [19:0] exp_ff, exp_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [1:0]         chunk_ff, chunk_in;
   logic [3:0]         rem10_ff, rem10_in;
   logic [31:0]        qrem_ff, qrem_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic signed [31:0] x_ff, x_in;
   logic               ysgn_ff, ysgn_in;
   logic               sub_ff, sub_in;
   logic signed [31:0] resm_ff, resm_in;
   logic signed [17:0] rese_ff, rese_in;
   logic signed [1:0]  ord_ff, ord_in;
   logic               ovalid_ff, ovalid_in;
   logic signed [31:0] om_ff, om_in;
   logic signed [17:0] oe_ff, oe_in;
   logic signed [1:0]  oo_ff, oo_in;

   logic [31:0]        pa;
   logic [31:0]        pb;
   logic [63:0]        int_part;
   logic [19:0]        num;
   logic [43:0]        num_prod;
   logic [15:0]        q10;
   logic [19:0]        r10;
   logic [6:0]         zdist;
   logic [63:0]        tval;
   logic [63:0]        up_base;
   logic [6:0]         up_shift;
   logic [63:0]        packed_mag;
   logic signed [33:0] xs;
   logic signed [33:0] ys;
   logic signed [33:0] sum;
   logic [32:0]        qr2;
   logic [31:0]        qr;
   logic [63:0]        qm;
   logic               out_free;

   function automatic logic [31:0] clamp_mant(input logic neg, input logic [63:0] mag);
      logic [31:0] r;
      if (neg) begin
         r = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
      end else begin
         r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return r;
   endfunction

   always_comb begin
      pa = item.x[31] ? 32'(-item.x) : item.x;
      pb = item.y[31] ? 32'(-item.y) : item.y;

      int_part = (shift_ff >= 7'd64) ? 64'd0 : (mag_ff >> shift_ff);

      // one 16-bit digit group of a divide by ten, msb group first
      num      = {((chunk_ff == 2'd0) ? 4'd0 : rem10_ff), mag_ff[63:48]};
      num_prod = 44'(num) * 44'(RECIP10);
      q10      = num_prod[42:27];
      r10      = num - {1'b0, q10, 3'b000} - {3'b000, q10, 1'b0};

      zdist = shift_ff - FB_SHIFT;
      if (shift_ff >= FB_SHIFT) begin
         tval = (zdist >= 7'd64) ? 64'd0 : (mag_ff >> zdist);
      end else begin
         tval = mag_ff;
      end

      // keep the times-ten step inside 64 bits
      if (mag_ff > MUL10_MAX) begin
         up_base  = mag_ff >> 4;
         up_shift = shift_ff - 7'd4;
      end else begin
         up_base  = mag_ff;
         up_shift = shift_ff;
      end

      if (shift_ff >= FB_SHIFT) begin
         packed_mag = mag_ff >> zdist;
      end else begin
         packed_mag = mag_ff << (FB_SHIFT - shift_ff);
      end

      xs  = {{2{x_ff[31]}}, x_ff};
      ys  = {2'b00, mag_ff[31:0]};
      ys  = ysgn_ff ? -ys : ys;
      sum = sub_ff ? (xs - ys) : (xs + ys);

      // two restoring quotient bits per cycle
      qr = qrem_ff;
      qm = mag_ff;
      for (int i = 0; i < 2; i++) begin
         qr2 = {qr, qm[63]};
         if (qr2 >= {1'b0, dvs_ff}) begin
            qr2 = qr2 - {1'b0, dvs_ff};
            qm  = {qm[62:0], 1'b1};
         end else begin
            qm  = {qm[62:0], 1'b0};
         end
         qr = qr2[31:0];
      end
   end

   assign out_free = !ovalid_ff || !rsp_stall;
   assign item_pop = (state_ff == S_IDLE) && item_valid;

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      shift_in  = shift_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      chunk_in  = chunk_ff;
      rem10_in  = rem10_ff;
      qrem_in   = qrem_ff;
      dvs_in    = dvs_ff;
      x_in      = x_ff;
      ysgn_in   = ysgn_ff;
      sub_in    = sub_ff;
      resm_in   = resm_ff;
      rese_in   = rese_ff;
      ord_in    = ord_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      om_in     = om_ff;
      oe_in     = oe_ff;
      oo_in     = oo_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               resm_in  = 32'sd0;
               rese_in  = 18'sd0;
               ord_in   = 2'sd0;
               exp_in   = item.e;
               neg_in   = item.x[31] ^ item.y[31];
               chunk_in = 2'd0;
               unique case (item.kind)
                  KIND_ORDER: begin
                     ord_in   = item.order;
                     state_in = S_DONE;
                  end
                  KIND_PASS: begin
                     resm_in  = item.x;
                     rese_in  = item.e[17:0];
                     state_in = S_DONE;
                  end
                  KIND_ADDSUB: begin
                     x_in     = item.x;
                     ysgn_in  = item.y[31];
                     sub_in   = item.sub;
                     mag_in   = {32'd0, pb};
                     cnt_in   = {1'b0, item.cnt};
                     state_in = S_ALIGN;
                  end
                  KIND_MUL: begin
                     mag_in   = 64'(pa) * 64'(pb);
                     shift_in = PROD_SHIFT;
                     state_in = S_ZCHK;
                  end
                  KIND_DIV: begin
                     mag_in   = {pa, 32'd0};
                     dvs_in   = pb;
                     qrem_in  = 32'd0;
                     cnt_in   = 5'd0;
                     shift_in = QUO_SHIFT;
                     state_in = S_QDIV;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ALIGN: begin
            if (cnt_ff == 5'd0) begin
               state_in = S_SUM;
            end else begin
               mag_in   = {mag_ff[47:0], q10};
               rem10_in = r10[3:0];
               chunk_in = chunk_ff + 2'd1;
               if (chunk_ff == 2'd3) begin
                  cnt_in = cnt_ff - 5'd1;
               end
            end
         end
         S_SUM: begin
            neg_in   = sum[33];
            mag_in   = 64'(sum[33] ? -sum : sum);
            shift_in = FB_SHIFT;
            state_in = S_ZCHK;
         end
         S_QDIV: begin
            qrem_in = qr;
            mag_in  = qm;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_ZCHK;
            end
         end
         S_ZCHK: begin
            state_in = (tval == 64'd0) ? S_DONE : S_DOWN;
         end
         S_DOWN: begin
            if ((chunk_ff == 2'd0) && (int_part < 64'd10)) begin
               state_in = S_UP;
            end else begin
               mag_in   = {mag_ff[47:0], q10};
               rem10_in = r10[3:0];
               chunk_in = chunk_ff + 2'd1;
               if (chunk_ff == 2'd3) begin
                  exp_in = exp_ff + 20'sd1;
               end
            end
         end
         S_UP: begin
            if (int_part != 64'd0) begin
               state_in = S_PACK;
            end else begin
               mag_in   = (up_base << 3) + (up_base << 1);
               shift_in = up_shift;
               exp_in   = exp_ff - 20'sd1;
            end
         end
         S_PACK: begin
            priority if (exp_ff >= ELIM) begin
               resm_in = clamp_mant(neg_ff, TOP);
               rese_in = ELIM[17:0];
            end else if (exp_ff < -ELIM) begin
               resm_in = 32'sd0;
               rese_in = 18'sd0;
            end else begin
               resm_in = clamp_mant(neg_ff, packed_mag);
               rese_in = exp_ff[17:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               om_in     = resm_ff;
               oe_in     = rese_ff;
               oo_in     = ord_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
         chunk_ff  <= 2'd0;
         cnt_ff    <= 5'd0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         chunk_ff  <= chunk_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      shift_ff <= shift_in;
      exp_ff   <= exp_in;
      rem10_ff <= rem10_in;
      qrem_ff  <= qrem_in;
      dvs_ff   <= dvs_in;
      x_ff     <= x_in;
      ysgn_ff  <= ysgn_in;
      sub_ff   <= sub_in;
      resm_ff  <= resm_in;
      rese_ff  <= rese_in;
      ord_ff   <= ord_in;
      om_ff    <= om_in;
      oe_ff    <= oe_in;
      oo_ff    <= oo_in;
   end

   assign rsp_valid        = ovalid_ff;
   assign rsp_res_mantissa = om_ff;
   assign rsp_res_exponent = oe_ff;
   assign rsp_order        = oo_ff;

`ifndef SYNTH
   a_div10_atomic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DOWN && chunk_ff != 2'd0) |=> state_ff == S_DOWN)
      else $error("divide by ten left mid-way");
   a_qrem_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_QDIV |-> qrem_ff < dvs_ff)
      else $error("partial remainder not below divisor");
   a_align_narrow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALIGN && chunk_ff == 2'd0) |-> mag_ff[63:32] == 32'd0)
      else $error("aligned operand grew past 32 bits");
`endif

endmodule
